FILE: src/ctc_pkg.sv
package ctc_pkg;

  localparam int SCORE_W    = 16;
  localparam int CLASS_W    = 16;
  localparam int STEP_W     = 10;
  localparam int SUM_W      = 26;
  localparam int COUNT_W    = 11;
  localparam int CLS_CFG_W  = 17;
  localparam int STEP_CFG_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 2'd1;

  localparam logic [CLS_CFG_W-1:0]  CLASS_COUNT_RESET = 17'd6625;
  localparam logic [CLS_CFG_W-1:0]  MIN_CLASSES       = 17'd2;
  localparam logic [CLS_CFG_W-1:0]  MAX_CLASSES       = 17'd65536;
  localparam logic [STEP_CFG_W-1:0] STEP_COUNT_RESET  = 11'd40;
  localparam logic [STEP_CFG_W-1:0] MIN_STEPS         = 11'd1;
  localparam logic [STEP_CFG_W-1:0] MAX_STEPS         = 11'd1024;

  localparam logic signed [SUM_W:0] SUM_HI = 27'sd33554431;
  localparam logic signed [SUM_W:0] SUM_LO = -27'sd33554432;
  localparam logic [COUNT_W-1:0]    COUNT_MAX = 11'd2047;

  typedef struct packed {
    logic [CLASS_W-1:0]        best_class;
    logic signed [SCORE_W-1:0] best_score;
  } step_rec_t;

  typedef struct packed {
    logic [CLASS_W-1:0]        best_class;
    logic signed [SCORE_W-1:0] best_score;
    logic                      emit;
    logic signed [SUM_W-1:0]   score_total;
    logic [COUNT_W-1:0]        symbol_total;
    logic                      sequence_end;
  } result_t;

endpackage

FILE: src/ctc_front.sv
module ctc_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [ctc_pkg::SCORE_W-1:0]    class_score,
  input  logic [ctc_pkg::CLS_CFG_W-1:0]         class_count,
  output logic                                  rec_push,
  output ctc_pkg::step_rec_t                    rec,
  input  logic                                  rec_full
);
  import ctc_pkg::*;

  logic [CLASS_W-1:0]        class_position;
  logic signed [SCORE_W-1:0] running_max;
  logic [CLASS_W-1:0]        running_argmax;
  logic [CLS_CFG_W-1:0]      eff_classes;
  logic [CLS_CFG_W-1:0]      pos_plus;
  logic                      accept;
  logic                      take;
  logic                      last;
  logic signed [SCORE_W-1:0] max_next;
  logic [CLASS_W-1:0]        arg_next;

  assign full   = rec_full;
  assign accept = push & ~rec_full;

  always_comb begin
    if (class_count < MIN_CLASSES) begin
      eff_classes = MIN_CLASSES;
    end else if (class_count > MAX_CLASSES) begin
      eff_classes = MAX_CLASSES;
    end else begin
      eff_classes = class_count;
    end
  end

  assign pos_plus = {1'b0, class_position} + CLS_CFG_W'(1);
  assign last     = pos_plus >= eff_classes;

  // First class of a step always loads; on a tie the earlier class stays
  assign take     = (class_position == '0) || (class_score > running_max);
  assign max_next = take ? class_score : running_max;
  assign arg_next = take ? class_position : running_argmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_position <= '0;
      running_argmax <= '0;
    end else if (accept) begin
      class_position <= last ? '0 : pos_plus[CLASS_W-1:0];
      running_argmax <= arg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      running_max <= max_next;
    end
  end

  assign rec_push        = accept & last;
  assign rec.best_class  = arg_next;
  assign rec.best_score  = max_next;

endmodule

FILE: src/ctc_step_queue.sv
module ctc_step_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ctc_pkg::step_rec_t din,
  output logic               full,
  input  logic               pop,
  output ctc_pkg::step_rec_t dout,
  output logic               valid
);
  import ctc_pkg::*;

  step_rec_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = count == 2'd2;
  assign valid   = count != 2'd0;
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/ctc_back.sv
module ctc_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 rec_valid,
  input  ctc_pkg::step_rec_t                   rec,
  output logic                                 rec_pop,
  input  logic [ctc_pkg::STEP_CFG_W-1:0]       step_count,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [ctc_pkg::CLASS_W-1:0]          best_class,
  output logic signed [ctc_pkg::SCORE_W-1:0]   best_score,
  output logic                                 emit,
  output logic signed [ctc_pkg::SUM_W-1:0]     score_total,
  output logic [ctc_pkg::COUNT_W-1:0]          symbol_total,
  output logic                                 sequence_end
);
  import ctc_pkg::*;

  logic [STEP_W-1:0]       step_pos;
  logic [CLASS_W-1:0]      prev_index;
  logic signed [SUM_W-1:0] score_sum;
  logic [COUNT_W-1:0]      symbol_count;

  logic [STEP_CFG_W-1:0]   eff_steps;
  logic [STEP_CFG_W-1:0]   step_plus;
  logic                    step_take;
  logic                    last;
  logic                    emit_now;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_next;
  logic [COUNT_W-1:0]      count_next;
  result_t                 res_in;

  result_t                 res_mem [2];
  logic                    res_wr;
  logic                    res_rd;
  logic [1:0]              res_count;
  logic                    res_full;
  logic                    res_pop;

  assign res_full  = res_count == 2'd2;
  assign empty     = res_count == 2'd0;
  assign res_pop   = pop & ~empty;
  assign step_take = rec_valid & ~res_full;
  assign rec_pop   = step_take;

  always_comb begin
    if (step_count < MIN_STEPS) begin
      eff_steps = MIN_STEPS;
    end else if (step_count > MAX_STEPS) begin
      eff_steps = MAX_STEPS;
    end else begin
      eff_steps = step_count;
    end
  end

  assign step_plus = {1'b0, step_pos} + STEP_CFG_W'(1);
  assign last      = step_plus >= eff_steps;

  // No repeat check on the first step of a sequence
  assign emit_now = (rec.best_class != '0) &&
                    !((step_pos != '0) && (rec.best_class == prev_index));

  assign sum_wide = {score_sum[SUM_W-1], score_sum} +
                    {{(SUM_W+1-SCORE_W){rec.best_score[SCORE_W-1]}}, rec.best_score};

  always_comb begin
    sum_next   = score_sum;
    count_next = symbol_count;
    if (emit_now) begin
      if (sum_wide > SUM_HI) begin
        sum_next = SUM_HI[SUM_W-1:0];
      end else if (sum_wide < SUM_LO) begin
        sum_next = SUM_LO[SUM_W-1:0];
      end else begin
        sum_next = sum_wide[SUM_W-1:0];
      end
      if (symbol_count != COUNT_MAX) begin
        count_next = symbol_count + COUNT_W'(1);
      end
    end
  end

  always_comb begin
    res_in.best_class   = rec.best_class;
    res_in.best_score   = rec.best_score;
    res_in.emit         = emit_now;
    res_in.score_total  = sum_next;
    res_in.symbol_total = count_next;
    res_in.sequence_end = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_pos     <= '0;
      prev_index   <= '0;
      score_sum    <= '0;
      symbol_count <= '0;
    end else if (step_take) begin
      prev_index <= rec.best_class;
      if (last) begin
        step_pos     <= '0;
        score_sum    <= '0;
        symbol_count <= '0;
      end else begin
        step_pos     <= step_plus[STEP_W-1:0];
        score_sum    <= sum_next;
        symbol_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_take) begin
      res_mem[res_wr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= 1'b0;
      res_rd    <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (step_take) begin
        res_wr <= ~res_wr;
      end
      if (res_pop) begin
        res_rd <= ~res_rd;
      end
      case ({step_take, res_pop})
        2'b10:   res_count <= res_count + 2'd1;
        2'b01:   res_count <= res_count - 2'd1;
        default: res_count <= res_count;
      endcase
    end
  end

  assign best_class   = res_mem[res_rd].best_class;
  assign best_score   = res_mem[res_rd].best_score;
  assign emit         = res_mem[res_rd].emit;
  assign score_total  = res_mem[res_rd].score_total;
  assign symbol_total = res_mem[res_rd].symbol_total;
  assign sequence_end = res_mem[res_rd].sequence_end;

  a_seq_restart: assert property (@(posedge clk) disable iff (rst)
    step_take && last |=> step_pos == '0)
    else $error("step position not cleared after sequence end");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    symbol_count <= {1'b0, step_pos})
    else $error("symbol count exceeds steps taken in sequence");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= 2'd2)
    else $error("result buffer overfilled");

endmodule

FILE: src/ctc_greedy_decoder_top.sv
// CTC greedy decoder: running argmax per time step, repeat/blank filter, totals.
// Throughput: one class score per cycle when full is low; one result per step.
// A step has class_count scores; its result passes the step queue register, then the
// result buffer register, before it reaches the ports; a full buffer can hold it back.
// Reset (rst, synchronous): positions, totals and queues clear; class_count = 6625,
// step_count = 40.
module ctc_greedy_decoder_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [ctc_pkg::SCORE_W-1:0]   class_score,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [ctc_pkg::CLASS_W-1:0]          best_class,
  output logic signed [ctc_pkg::SCORE_W-1:0]   best_score,
  output logic                                 emit,
  output logic signed [ctc_pkg::SUM_W-1:0]     score_total,
  output logic [ctc_pkg::COUNT_W-1:0]          symbol_total,
  output logic                                 sequence_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ctc_pkg::*;

  logic [CLS_CFG_W-1:0]  class_count;
  logic [STEP_CFG_W-1:0] step_count;

  logic      rec_push;
  logic      rec_full;
  step_rec_t rec_in;
  logic      rec_valid;
  logic      rec_pop;
  step_rec_t rec_out;

  assign cfg_ready = 1'b1;

  // Unknown register indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= CLASS_COUNT_RESET;
      step_count  <= STEP_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLASS_COUNT: class_count <= cfg_data[CLS_CFG_W-1:0];
        REG_STEP_COUNT:  step_count  <= cfg_data[STEP_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ctc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .class_score (class_score),
    .class_count (class_count),
    .rec_push    (rec_push),
    .rec         (rec_in),
    .rec_full    (rec_full)
  );

  ctc_step_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .din   (rec_in),
    .full  (rec_full),
    .pop   (rec_pop),
    .dout  (rec_out),
    .valid (rec_valid)
  );

  ctc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rec_valid    (rec_valid),
    .rec          (rec_out),
    .rec_pop      (rec_pop),
    .step_count   (step_count),
    .empty        (empty),
    .pop          (pop),
    .best_class   (best_class),
    .best_score   (best_score),
    .emit         (emit),
    .score_total  (score_total),
    .symbol_total (symbol_total),
    .sequence_end (sequence_end)
  );

endmodule

FILE: bench/ctc_greedy_decoder_checker.sv
`timescale 1ns / 1ps

module ctc_greedy_decoder_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic                               full,
  input  logic signed [ctc_pkg::SCORE_W-1:0] class_score,
  input  logic                               empty,
  input  logic                               pop,
  input  logic [ctc_pkg::CLASS_W-1:0]        best_class,
  input  logic signed [ctc_pkg::SCORE_W-1:0] best_score,
  input  logic                               emit,
  input  logic signed [ctc_pkg::SUM_W-1:0]   score_total,
  input  logic [ctc_pkg::COUNT_W-1:0]        symbol_total,
  input  logic                               sequence_end,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 error_count,
  output int                                 steps_in_flight,
  output int                                 steps_decoded
);
  import ctc_pkg::*;

  // Decoder copy: configuration and per-step / per-sequence state
  logic [CLS_CFG_W-1:0]      classes_reg;
  logic [STEP_CFG_W-1:0]     steps_reg;
  logic [CLASS_W-1:0]        class_pos;
  logic [STEP_W-1:0]         step_pos;
  logic signed [SCORE_W-1:0] peak_score;
  logic [CLASS_W-1:0]        peak_class;
  logic [CLASS_W-1:0]        last_winner;
  logic signed [SUM_W-1:0]   emitted_sum;
  logic [COUNT_W-1:0]        emitted_count;

  result_t decoded_steps[$];

  function automatic logic [CLS_CFG_W-1:0] class_limit();
    if (classes_reg < MIN_CLASSES) return MIN_CLASSES;
    if (classes_reg > MAX_CLASSES) return MAX_CLASSES;
    return classes_reg;
  endfunction

  function automatic logic [STEP_CFG_W-1:0] step_limit();
    if (steps_reg < MIN_STEPS) return MIN_STEPS;
    if (steps_reg > MAX_STEPS) return MAX_STEPS;
    return steps_reg;
  endfunction

  task automatic decode_score(input logic signed [SCORE_W-1:0] score);
    logic signed [SUM_W:0] acc;
    logic                  fresh;
    logic                  last;
    result_t               step_res;
    // earlier class wins a tie, so only a strictly larger score takes over
    if (class_pos == '0 || score > peak_score) begin
      peak_score = score;
      peak_class = class_pos;
    end
    if ({1'b0, class_pos} + 17'd1 < class_limit()) begin
      class_pos = class_pos + 1'b1;
      return;
    end
    class_pos = '0;

    fresh = (peak_class != '0) && !(step_pos != '0 && peak_class == last_winner);
    if (fresh) begin
      acc = emitted_sum + peak_score;
      if (acc > SUM_HI) acc = SUM_HI;
      else if (acc < SUM_LO) acc = SUM_LO;
      emitted_sum = acc[SUM_W-1:0];
      if (emitted_count != COUNT_MAX) emitted_count = emitted_count + 1'b1;
    end
    last_winner = peak_class;
    last = ({1'b0, step_pos} + 11'd1) >= step_limit();

    step_res.best_class   = peak_class;
    step_res.best_score   = peak_score;
    step_res.emit         = fresh;
    step_res.score_total  = emitted_sum;
    step_res.symbol_total = emitted_count;
    step_res.sequence_end = last;
    decoded_steps = {decoded_steps, step_res};
    steps_decoded++;

    if (last) begin
      step_pos      = '0;
      emitted_sum   = '0;
      emitted_count = '0;
    end else begin
      step_pos = step_pos + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      classes_reg   = CLASS_COUNT_RESET;
      steps_reg     = STEP_COUNT_RESET;
      class_pos     = '0;
      step_pos      = '0;
      peak_score    = '0;
      peak_class    = '0;
      last_winner   = '0;
      emitted_sum   = '0;
      emitted_count = '0;
      error_count   = 0;
      steps_decoded = 0;
      decoded_steps.delete();
    end else begin
      if (pop && !empty) begin
        if (decoded_steps.size() == 0) begin
          $error("result transfer with nothing expected: best_class %0d", best_class);
          error_count++;
        end else begin
          want = decoded_steps.pop_front();
          check_field("best_class", longint'(want.best_class), longint'(best_class));
          check_field("best_score", longint'(want.best_score), longint'(best_score));
          check_field("emit", longint'(want.emit), longint'(emit));
          check_field("score_total", longint'(want.score_total), longint'(score_total));
          check_field("symbol_total", longint'(want.symbol_total),
                      longint'(symbol_total));
          check_field("sequence_end", longint'(want.sequence_end),
                      longint'(sequence_end));
        end
      end
      if (push && !full) decode_score(class_score);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CLASS_COUNT: classes_reg = cfg_data[CLS_CFG_W-1:0];
          REG_STEP_COUNT:  steps_reg = cfg_data[STEP_CFG_W-1:0];
          default: ;  // drop writes to unmapped indexes
        endcase
      end
    end
    steps_in_flight = decoded_steps.size();
  end

endmodule

FILE: bench/tb_ctc_greedy_decoder_top.sv
`timescale 1ns / 1ps

module tb_ctc_greedy_decoder_top;
  import ctc_pkg::*;

  localparam int CYCLE_LIMIT    = 1500000;
  localparam int LATENCY_SLACK  = 8;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES  = 10;
  localparam int LONG_STEPS     = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                      clk;
  logic                      rst;
  logic                      push;
  logic                      full;
  logic signed [SCORE_W-1:0] class_score;
  logic                      empty;
  logic                      pop;
  logic [CLASS_W-1:0]        best_class;
  logic signed [SCORE_W-1:0] best_score;
  logic                      emit;
  logic signed [SUM_W-1:0]   score_total;
  logic [COUNT_W-1:0]        symbol_total;
  logic                      sequence_end;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  int error_count;
  int steps_in_flight;
  int steps_decoded;
  int cycle_count;

  logic rx_hold_req;
  logic rx_hold_done;
  int   rx_idle_left;
  int   rx_burst_left;

  // blank first, then a win, a repeat, a new sequence with the same winner,
  // and an all-negative step won by the last class
  logic signed [SCORE_W-1:0] directed_scores [20] = '{
    16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005,
    16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh0000,
    16'sh8000, 16'sh7FFF, 16'sh0001, 16'sh7FFF,
    16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
    16'sh8000, 16'sh8000, 16'sh8000, 16'shFFFF
  };

  ctc_greedy_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .class_score  (class_score),
    .empty        (empty),
    .pop          (pop),
    .best_class   (best_class),
    .best_score   (best_score),
    .emit         (emit),
    .score_total  (score_total),
    .symbol_total (symbol_total),
    .sequence_end (sequence_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ctc_greedy_decoder_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .class_score     (class_score),
    .empty           (empty),
    .pop             (pop),
    .best_class      (best_class),
    .best_score      (best_score),
    .emit            (emit),
    .score_total     (score_total),
    .symbol_total    (symbol_total),
    .sequence_end    (sequence_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .steps_in_flight (steps_in_flight),
    .steps_decoded   (steps_decoded)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score();
    int v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2, 3: v = $urandom_range(0, 6) - 3;  // narrow range: ties and repeats
      4:    v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = $urandom_range(0, 255) - 128;
    endcase
    return v[SCORE_W-1:0];
  endfunction

  // any score short of the top value, so a planted peak wins the step
  function automatic logic signed [SCORE_W-1:0] score_below_peak();
    logic signed [SCORE_W-1:0] s;
    s = pick_score();
    return (s == 16'sh7FFF) ? 16'sh7FFE : s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_class_count();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'd2;
      3: return CFG_DATA_W'($urandom_range(17, 40));
      default: return CFG_DATA_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step_count();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return 17'd1;
      2: return {{(CFG_DATA_W-STEP_CFG_W){1'b0}}, {STEP_CFG_W{1'b1}}};
      default: return CFG_DATA_W'($urandom_range(2, 6));
    endcase
  endfunction

  // keep push high across back-to-back transfers; drop it only for a gap
  task automatic send_score(input logic signed [SCORE_W-1:0] s, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push        <= 1'b1;
    class_score <= s;
    do @(posedge clk); while (full);
  endtask

  task automatic quiesce();
    @(negedge clk);
    push <= 1'b0;
    while (steps_in_flight != 0) @(negedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // bring the stream to the start of a step and of a sequence
  task automatic align_stream();
    int seen;
    write_reg(REG_CLASS_COUNT, CFG_DATA_W'(MIN_CLASSES));
    write_reg(REG_STEP_COUNT, CFG_DATA_W'(MIN_STEPS));
    seen = steps_decoded;
    send_score(pick_score(), 0);
    quiesce();
    if (steps_decoded == seen) begin
      send_score(pick_score(), 0);
      quiesce();
    end
  endtask

  // receiver: random pop gaps and bursts, plus one long hold-off on request
  initial begin
    pop           = 1'b0;
    rx_hold_done  = 1'b0;
    rx_idle_left  = 0;
    rx_burst_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        rx_idle_left = RX_HOLD_CYCLES;
      end
      if (rx_idle_left > 0) begin
        pop <= 1'b0;
        rx_idle_left--;
      end else begin
        pop <= 1'b1;
        if (rx_burst_left > 0) rx_burst_left--;
        else if ($urandom_range(0, 4) == 0) rx_burst_left = $urandom_range(10, 80);
        else rx_idle_left = pick_gap();
      end
    end
  end

  initial begin
    int   items;
    logic steady;
    rst         = 1'b1;
    push        = 1'b0;
    class_score = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_CLASS_COUNT;
    cfg_data    = '0;
    rx_hold_req = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one full sequence at the reset step count, two classes per step
    write_reg(REG_CLASS_COUNT, CFG_DATA_W'(MIN_CLASSES));
    for (int i = 0; i < 2 * int'(STEP_COUNT_RESET); i++)
      send_score(pick_score(), pick_gap());
    quiesce();

    align_stream();
    write_reg(REG_CLASS_COUNT, 17'd4);
    write_reg(REG_STEP_COUNT, 17'd3);
    foreach (directed_scores[i]) send_score(directed_scores[i], pick_gap());
    quiesce();

    // random phases; registers change between them, usually mid-step
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 1) begin
        write_reg(REG_CLASS_COUNT, CFG_DATA_W'(MIN_CLASSES));
        write_reg(REG_STEP_COUNT, CFG_DATA_W'($urandom_range(1, 6)));
        rx_hold_req = 1'b1;
        for (int i = 0; i < 200; i++) send_score(pick_score(), 0);
      end else begin
        if ($urandom_range(0, 2) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                    CFG_DATA_W'($urandom));
        if ($urandom_range(0, 4) != 0) write_reg(REG_CLASS_COUNT, pick_class_count());
        if ($urandom_range(0, 4) != 0) write_reg(REG_STEP_COUNT, pick_step_count());
        steady = ($urandom_range(0, 3) == 0);
        items  = $urandom_range(40, 70);
        for (int i = 0; i < items; i++) send_score(pick_score(), steady ? 0 : pick_gap());
      end
      quiesce();
    end

    // every step emits the top score; the step count shrinks mid-sequence
    align_stream();
    write_reg(REG_CLASS_COUNT, 17'd3);
    write_reg(REG_STEP_COUNT, {{(CFG_DATA_W-STEP_CFG_W){1'b0}}, {STEP_CFG_W{1'b1}}});
    for (int k = 0; k < LONG_STEPS; k++) begin
      if (k == 25) begin
        quiesce();
        write_reg(REG_STEP_COUNT, CFG_DATA_W'(LONG_STEPS));
      end
      for (int c = 0; c < 3; c++)
        send_score((c == 1 + k % 2) ? 16'sh7FFF : score_below_peak(), pick_gap());
    end
    quiesce();

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
